### rtl/ise_pkg.sv
// shared types and constants for the insertion sort engine
`default_nettype none

package ise_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 32;
  localparam int MAX_RESULTS  = 32;
  localparam int EMIT_W       = $clog2(MAX_RESULTS);

  // operation applied to every cell in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_INS   = 2'd1,
    CELL_SHIFT = 2'd2,
    CELL_CLEAR = 2'd3
  } cell_op_e;

  // control broadcast from the sequencer to the chain
  typedef struct packed {
    cell_op_e                   op;
    logic signed [DATA_W-1:0]   value;
  } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/ise_cell.sv
// one compare-and-shift cell of the sorting chain
`default_nettype none

module ise_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ise_pkg::cell_ctl_t                  ctl_i,
  input  logic                                prev_gt_i,
  input  logic                                prev_valid_i,
  input  logic signed [ise_pkg::DATA_W-1:0]   prev_val_i,
  input  logic                                next_valid_i,
  input  logic signed [ise_pkg::DATA_W-1:0]   next_val_i,
  output logic                                gt_o,
  output logic                                valid_o,
  output logic signed [ise_pkg::DATA_W-1:0]   val_o
);
  import ise_pkg::*;

  logic                       valid_q, valid_d;
  logic signed [DATA_W-1:0]   val_q, val_d;

  // entry is occupied and strictly above the incoming value
  assign gt_o = valid_q && (val_q > ctl_i.value);

  // next cell contents
  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    case (ctl_i.op)
      CELL_INS: begin
        if (prev_gt_i) begin
          val_d   = prev_val_i;
          valid_d = 1'b1;
        end else if (gt_o || (!valid_q && prev_valid_i)) begin
          val_d   = ctl_i.value;
          valid_d = 1'b1;
        end
      end
      CELL_SHIFT: begin
        val_d   = next_val_i;
        valid_d = next_valid_i;
      end
      CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stored value, no reset needed
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign valid_o = valid_q;
  assign val_o   = val_q;

endmodule

`default_nettype wire

### rtl/insertion_sort_engine_top.sv
// top level of the insertion sort engine: cell chain and sequencer
// each accepted beat is inserted into the chain; after a last beat, min(count, 32)
// result beats follow, one per cycle while m_axis_tready_i
// throughput: one input beat per cycle while collecting; the chain of CAPACITY cells
// compares all entries against the incoming value in parallel and shifts in one step
// input is not taken while results drain; the next set starts the cycle after the final beat
// reset clears count, overflow flag and all occupancy bits; no clearing pass is needed
`default_nettype none

module insertion_sort_engine_top #(
  parameter int CAPACITY = ise_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [ise_pkg::DATA_W-1:0]          s_axis_tdata_i,  // [31:0] value
  input  logic                                s_axis_tlast_i,  // last
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [ise_pkg::DATA_W-1:0]          m_axis_tdata_o,  // [31:0] sorted_value
  output logic                                m_axis_tlast_o,  // final_res
  output logic                                m_axis_tuser_o   // [0] overflow
);
  import ise_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                     state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [EMIT_W-1:0]        emit_q, emit_d;
  logic                     drop_q, drop_d;

  logic                     in_beat, out_beat, full, final_beat;
  cell_ctl_t                ctl;

  logic                     gt    [CAPACITY];
  logic                     vld   [CAPACITY];
  logic signed [DATA_W-1:0] val   [CAPACITY];

  // handshake and status
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_DRAIN);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat        = m_axis_tvalid_o && m_axis_tready_i;
  assign full            = (cnt_q == CNT_W'(CAPACITY));
  assign final_beat      = (cnt_q == CNT_W'(1)) || (emit_q == EMIT_W'(MAX_RESULTS - 1));

  // chain control
  always_comb begin
    ctl.value = signed'(s_axis_tdata_i);
    ctl.op    = CELL_HOLD;
    if (in_beat && !full) begin
      ctl.op = CELL_INS;
    end else if (out_beat) begin
      ctl.op = final_beat ? CELL_CLEAR : CELL_SHIFT;
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     p_gt, p_vld, n_vld;
    logic signed [DATA_W-1:0] p_val, n_val;
    if (i == 0) begin : g_head
      assign p_gt  = 1'b0;
      assign p_vld = 1'b1;
      assign p_val = '0;
    end else begin : g_body
      assign p_gt  = gt[i-1];
      assign p_vld = vld[i-1];
      assign p_val = val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign n_vld = 1'b0;
      assign n_val = '0;
    end else begin : g_link
      assign n_vld = vld[i+1];
      assign n_val = val[i+1];
    end
    ise_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .prev_gt_i    (p_gt),
      .prev_valid_i (p_vld),
      .prev_val_i   (p_val),
      .next_valid_i (n_vld),
      .next_val_i   (n_val),
      .gt_o         (gt[i]),
      .valid_o      (vld[i]),
      .val_o        (val[i])
    );
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    emit_d  = emit_q;
    drop_d  = drop_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (s_axis_tlast_i) begin
            state_d = ST_DRAIN;
            emit_d  = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (out_beat) begin
          if (final_beat) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
            drop_d  = 1'b0;
          end else begin
            cnt_d  = cnt_q - CNT_W'(1);
            emit_d = emit_q + EMIT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      emit_q  <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      emit_q  <= emit_d;
      drop_q  <= drop_d;
    end
  end

  // result beat comes straight from the head cell
  assign m_axis_tdata_o = unsigned'(val[0]);
  assign m_axis_tlast_o = final_beat;
  assign m_axis_tuser_o = drop_q;

  // checks
  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> vld[0])
    else $error("result beat without an occupied head cell");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_final_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && m_axis_tlast_o) |=> (cnt_q == '0) && !drop_q && !vld[0])
    else $error("set not cleared after final beat");

  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ((cnt_q == '0) == !vld[0]))
    else $error("fill count disagrees with head occupancy");

endmodule

`default_nettype wire
